@@ sv/rpmc_pkg.sv @@
// Package: command codes, motion states and register indexes of the position controller.
`default_nettype none
package rpmc_pkg;

	localparam int FUNC_BITS     = 3;
	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam int STATE_BITS    = 2;

	typedef enum logic [FUNC_BITS-1:0] {
		FUNC_TICK      = 3'd0,
		FUNC_MOVE      = 3'd1,
		FUNC_START_FWD = 3'd2,
		FUNC_START_REV = 3'd3,
		FUNC_STOP      = 3'd4
	} func_t;

	// internal one-hot motion state
	typedef enum logic [2:0] {
		MS_IDLE = 3'b001,
		MS_FWD  = 3'b010,
		MS_REV  = 3'b100
	} motion_t;

	// codes shown on motor_state
	localparam logic [STATE_BITS-1:0] STATE_CODE_IDLE = 2'd0;
	localparam logic [STATE_BITS-1:0] STATE_CODE_FWD  = 2'd1;
	localparam logic [STATE_BITS-1:0] STATE_CODE_REV  = 2'd2;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MAX_POSITION     = 3'd0,
		REG_MIN_POSITION     = 3'd1,
		REG_ARRIVE_THRESHOLD = 3'd2,
		REG_SLOW_ZONE        = 3'd3,
		REG_RAMP_STEP        = 3'd4,
		REG_FULL_SPEED       = 3'd5
	} cfg_reg_t;

	localparam int RESET_ARRIVE_THRESHOLD = 50;
	localparam int RESET_SLOW_ZONE        = 500;
	localparam int RESET_RAMP_STEP        = 400;

endpackage
`default_nettype wire

@@ sv/rpmc_cmd_if.sv @@
// Interface: command / tick input channel.
`default_nettype none
interface rpmc_cmd_if #(
	parameter int POS_BITS = 12
);
	import rpmc_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [FUNC_BITS-1:0] func;
	logic [POS_BITS-1:0]  requested_position;
	logic [POS_BITS-1:0]  sensor_sample;

	modport source(output valid, func, requested_position, sensor_sample, input ready);
	modport sink(input valid, func, requested_position, sensor_sample, output ready);
endinterface
`default_nettype wire

@@ sv/rpmc_res_if.sv @@
// Interface: result channel carrying duty, sensor power and motor state.
`default_nettype none
interface rpmc_res_if #(
	parameter int PWM_BITS = 13
);
	import rpmc_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [PWM_BITS-1:0]   forward_duty;
	logic [PWM_BITS-1:0]   reverse_duty;
	logic                  sensor_power;
	logic [STATE_BITS-1:0] motor_state;
	logic                  state_changed;

	modport source(output valid, forward_duty, reverse_duty, sensor_power, motor_state,
		state_changed, input ready);
	modport sink(input valid, forward_duty, reverse_duty, sensor_power, motor_state,
		state_changed, output ready);
endinterface
`default_nettype wire

@@ sv/rpmc_cfg_if.sv @@
// Interface: configuration write channel.
`default_nettype none
interface rpmc_cfg_if;
	import rpmc_pkg::*;
	logic                     valid;
	logic                     ready;
	logic [CFG_IDX_BITS-1:0]  index;
	logic [CFG_DATA_BITS-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ sv/ramped_position_motor_controller_top.sv @@
// Top level: ramped bang-bang position controller with registered result.
//
//  channel | dir | fields
//  cmd     | in  | func, requested_position, sensor_sample
//  res     | out | forward_duty, reverse_duty, sensor_power, motor_state, state_changed
//  cfg     | in  | index, data (write only, always ready)
//
// One item per cycle while res is not stalled: the state update is one pass through the clamp, error compare
// and slew adder, written into the state and result registers at the transfer.
// res valid rises in the cycle after the cmd transfer.
// cmd is ready whenever the result register is empty or being taken in the same cycle.
// arst_n clears state, result valid and loads the register defaults.
`default_nettype none
module ramped_position_motor_controller_top #(
	parameter int POS_BITS = 12,
	parameter int PWM_BITS = 13
) (
	input wire logic clk,
	input wire logic arst_n,
	rpmc_cmd_if.sink   cmd,
	rpmc_res_if.source res,
	rpmc_cfg_if.sink   cfg
);
	import rpmc_pkg::*;

	localparam int SW = PWM_BITS + 2;
	localparam int EW = POS_BITS + 1;

	// configuration registers
	logic [POS_BITS-1:0] max_pos_q, min_pos_q, arrive_thr_q, slow_zone_q;
	logic [PWM_BITS-1:0] ramp_step_q, full_speed_q;

	// controller state
	logic [POS_BITS-1:0] target_q, target_d;
	logic signed [SW-1:0] cmd_speed_q, cmd_speed_d;
	logic signed [SW-1:0] speed_q, speed_d;
	motion_t              motion_q, motion_d;
	logic                 sensor_on_q, sensor_on_d;

	logic res_valid_q;
	logic accept;

	assign cfg.ready = 1'b1;
	assign cmd.ready = !res_valid_q || res.ready;
	assign accept    = cmd.valid && cmd.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_pos_q    <= '1;
			min_pos_q    <= '0;
			arrive_thr_q <= POS_BITS'(RESET_ARRIVE_THRESHOLD);
			slow_zone_q  <= POS_BITS'(RESET_SLOW_ZONE);
			ramp_step_q  <= PWM_BITS'(RESET_RAMP_STEP);
			full_speed_q <= '1;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				REG_MAX_POSITION:     max_pos_q    <= cfg.data[POS_BITS-1:0];
				REG_MIN_POSITION:     min_pos_q    <= cfg.data[POS_BITS-1:0];
				REG_ARRIVE_THRESHOLD: arrive_thr_q <= cfg.data[POS_BITS-1:0];
				REG_SLOW_ZONE:        slow_zone_q  <= cfg.data[POS_BITS-1:0];
				REG_RAMP_STEP:        ramp_step_q  <= cfg.data[PWM_BITS-1:0];
				REG_FULL_SPEED:       full_speed_q <= cfg.data[PWM_BITS-1:0];
				default: ;
			endcase
		end
	end

	// error to target and ramp goal
	logic signed [EW-1:0] err;
	logic        [EW-1:0] mag;
	logic                 arrived, in_slow;
	logic signed [SW-1:0] half_cmd, goal, slewed, full_s;
	logic                 moving;

	assign full_s   = signed'({2'b00, full_speed_q});
	assign err      = signed'({1'b0, target_q}) - signed'({1'b0, cmd.sensor_sample});
	assign mag      = err[EW-1] ? EW'(-err) : EW'(err);
	assign arrived  = mag < {1'b0, arrive_thr_q};
	assign in_slow  = mag < {1'b0, slow_zone_q};
	// halve truncating toward zero
	assign half_cmd = (cmd_speed_q + signed'(SW'(cmd_speed_q[SW-1]))) >>> 1;
	assign moving   = (motion_q == MS_FWD) || (motion_q == MS_REV);
	assign goal     = !moving ? '0 : (in_slow ? half_cmd : cmd_speed_q);

	rpmc_slew #(.PWM_BITS(PWM_BITS)) u_slew (
		.speed      (speed_q),
		.goal       (goal),
		.step       (ramp_step_q),
		.speed_next (slewed)
	);

	always_comb begin
		target_d    = target_q;
		cmd_speed_d = cmd_speed_q;
		speed_d     = speed_q;
		motion_d    = motion_q;
		sensor_on_d = sensor_on_q;
		case (cmd.func)
			FUNC_TICK: begin
				if (moving && arrived) begin
					target_d = '0;
					motion_d = MS_IDLE;
				end else begin
					speed_d = slewed;
					if (slewed == '0) sensor_on_d = 1'b0;
				end
			end
			FUNC_MOVE: begin
				if (cmd.requested_position > max_pos_q) target_d = max_pos_q;
				else if (cmd.requested_position < min_pos_q) target_d = min_pos_q;
				else target_d = cmd.requested_position;
				sensor_on_d = 1'b1;
				// direction judged against the unclamped request
				if (cmd.sensor_sample < cmd.requested_position) begin
					cmd_speed_d = full_s;
					motion_d    = MS_FWD;
				end else begin
					cmd_speed_d = -full_s;
					motion_d    = MS_REV;
				end
			end
			FUNC_START_FWD: begin
				cmd_speed_d = full_s;
				target_d    = max_pos_q;
				motion_d    = MS_FWD;
				sensor_on_d = 1'b1;
			end
			FUNC_START_REV: begin
				cmd_speed_d = -full_s;
				target_d    = min_pos_q;
				motion_d    = MS_REV;
				sensor_on_d = 1'b1;
			end
			FUNC_STOP: begin
				target_d = '0;
				motion_d = MS_IDLE;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q    <= '0;
			cmd_speed_q <= '0;
			speed_q     <= '0;
			motion_q    <= MS_IDLE;
			sensor_on_q <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				target_q    <= target_d;
				cmd_speed_q <= cmd_speed_d;
				speed_q     <= speed_d;
				motion_q    <= motion_d;
				sensor_on_q <= sensor_on_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	logic [PWM_BITS-1:0]   fwd_q, rev_q;
	logic                  power_q, changed_q;
	logic [STATE_BITS-1:0] state_code_q, state_code_d;
	logic signed [SW-1:0]  neg_speed;

	assign neg_speed = -speed_d;

	always_comb begin
		case (motion_d)
			MS_FWD:  state_code_d = STATE_CODE_FWD;
			MS_REV:  state_code_d = STATE_CODE_REV;
			default: state_code_d = STATE_CODE_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			fwd_q        <= speed_d[SW-1] ? '0 : speed_d[PWM_BITS-1:0];
			rev_q        <= speed_d[SW-1] ? neg_speed[PWM_BITS-1:0] : '0;
			power_q      <= sensor_on_d;
			state_code_q <= state_code_d;
			changed_q    <= motion_d != motion_q;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.forward_duty  = fwd_q;
	assign res.reverse_duty  = rev_q;
	assign res.sensor_power  = power_q;
	assign res.motor_state   = state_code_q;
	assign res.state_changed = changed_q;
endmodule
`default_nettype wire

@@ sv/rpmc_slew.sv @@
// Slew limiter: moves the speed toward a goal by at most one ramp step.
`default_nettype none
module rpmc_slew #(
	parameter int PWM_BITS = 13
) (
	input  wire logic signed [PWM_BITS+1:0] speed,
	input  wire logic signed [PWM_BITS+1:0] goal,
	input  wire logic        [PWM_BITS-1:0] step,
	output logic signed      [PWM_BITS+1:0] speed_next
);
	localparam int SW = PWM_BITS + 2;

	logic signed [SW-1:0] step_s;
	logic signed [SW-1:0] up;
	logic signed [SW-1:0] dn;

	assign step_s = signed'({2'b00, step});
	assign up     = speed + step_s;
	assign dn     = speed - step_s;

	always_comb begin
		if (speed < goal) begin
			speed_next = (up > goal) ? goal : up;
		end else if (speed > goal) begin
			speed_next = (dn < goal) ? goal : dn;
		end else begin
			speed_next = speed;
		end
	end
endmodule
`default_nettype wire

@@ tb/tb.sv @@
// Testbench for the ramped position motor controller: directed table, random phases, scoreboard.
`default_nettype none
module tb;
	import rpmc_pkg::*;

	localparam int POS_BITS = 12;
	localparam int PWM_BITS = 13;
	localparam int DIR_ROWS = 25;
	localparam int PHASE_ITEMS = 100;
	localparam int PHASES = 7;
	localparam int SQUEEZE_CYCLES = 40;

	// func codes the block has to ignore
	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_5 = 3'd5;
	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
	localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

	typedef struct packed {
		logic [PWM_BITS-1:0]   fwd;
		logic [PWM_BITS-1:0]   rev;
		logic                  pwr;
		logic [STATE_BITS-1:0] st;
		logic                  chg;
	} drive_out_t;

	typedef struct packed {
		logic [FUNC_BITS-1:0] f;
		logic [POS_BITS-1:0]  req;
		logic [POS_BITS-1:0]  smp;
		logic                 typed;
		drive_out_t           res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	rpmc_cmd_if #(.POS_BITS(POS_BITS)) cmd_if ();
	rpmc_res_if #(.PWM_BITS(PWM_BITS)) res_if ();
	rpmc_cfg_if cfg_if ();

	ramped_position_motor_controller_top #(
		.POS_BITS(POS_BITS),
		.PWM_BITS(PWM_BITS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_if),
		.res(res_if),
		.cfg(cfg_if)
	);

	always #5 clk = ~clk;

	// controller shadow: settings and state
	int lim_max, lim_min, arrive_thr, slow_thr, step_max, speed_full;
	logic [POS_BITS-1:0]   tgt_pos;
	int                    cmd_speed;
	int                    ramp_speed;
	logic [STATE_BITS-1:0] mstate;
	logic                  sens_on;

	drive_out_t duty_expected_q[$];
	int fail_count = 0;
	bit src_steady = 1'b0;
	bit sink_steady = 1'b0;
	bit squeeze_req = 1'b0;

	// Directed rows under reset settings; typed rows carry their expected result.
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{FUNC_TICK,      12'd0,    12'd0,    1'b1, '{13'd0,    13'd0,   1'b0, STATE_CODE_IDLE, 1'b0}},
		'{FUNC_MOVE,      12'd4095, 12'd0,    1'b1, '{13'd0,    13'd0,   1'b1, STATE_CODE_FWD,  1'b1}},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b1, '{13'd400,  13'd0,   1'b1, STATE_CODE_FWD,  1'b0}},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b1, '{13'd800,  13'd0,   1'b1, STATE_CODE_FWD,  1'b0}},
		'{FUNC_TICK,      12'd0,    12'd4000, 1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd4060, 1'b1, '{13'd1200, 13'd0,   1'b1, STATE_CODE_IDLE, 1'b1}},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b1, '{13'd0,    13'd0,   1'b0, STATE_CODE_IDLE, 1'b0}},
		'{FUNC_START_REV, 12'd0,    12'd0,    1'b1, '{13'd0,    13'd0,   1'b1, STATE_CODE_REV,  1'b1}},
		'{FUNC_TICK,      12'd0,    12'd4095, 1'b1, '{13'd0,    13'd400, 1'b1, STATE_CODE_REV,  1'b0}},
		'{FUNC_START_FWD, 12'd0,    12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_MOVE,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd30,   1'b0, '0},
		'{FUNC_MOVE,      12'd2000, 12'd2000, 1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd1700, 1'b0, '0},
		'{FUNC_SPARE_5,   12'd4095, 12'd4095, 1'b0, '0},
		'{FUNC_SPARE_7,   12'd0,    12'd0,    1'b0, '0},
		'{FUNC_STOP,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_STOP,      12'd0,    12'd0,    1'b0, '0},
		'{FUNC_MOVE,      12'd4095, 12'd4095, 1'b0, '0},
		'{FUNC_SPARE_6,   12'd4095, 12'd0,    1'b0, '0},
		'{FUNC_TICK,      12'd0,    12'd4095, 1'b0, '0}
	};

	function automatic void slew_toward(int goal);
		if (ramp_speed < goal)
			ramp_speed = (ramp_speed + step_max > goal) ? goal : ramp_speed + step_max;
		else if (ramp_speed > goal)
			ramp_speed = (ramp_speed - step_max < goal) ? goal : ramp_speed - step_max;
		if (ramp_speed == 0)
			sens_on = 1'b0;
	endfunction

	function automatic drive_out_t controller_step(logic [FUNC_BITS-1:0] f,
			logic [POS_BITS-1:0] req, logic [POS_BITS-1:0] smp);
		logic [STATE_BITS-1:0] prior;
		int err;
		int mag;
		int goal;
		int neg;
		drive_out_t o;
		prior = mstate;
		case (f)
			FUNC_TICK: begin
				if (mstate != STATE_CODE_IDLE) begin
					err = int'(tgt_pos) - int'(smp);
					mag = (err < 0) ? -err : err;
					if (mag < arrive_thr) begin
						tgt_pos = '0;
						mstate = STATE_CODE_IDLE;
					end else begin
						goal = cmd_speed;
						if (mag < slow_thr)
							goal = goal / 2;
						slew_toward(goal);
					end
				end else begin
					slew_toward(0);
				end
			end
			FUNC_MOVE: begin
				// clamp against max first, then min
				if (int'(req) > lim_max)
					tgt_pos = lim_max[POS_BITS-1:0];
				else if (int'(req) < lim_min)
					tgt_pos = lim_min[POS_BITS-1:0];
				else
					tgt_pos = req;
				sens_on = 1'b1;
				// direction from the unclamped request
				if (smp < req) begin
					cmd_speed = speed_full;
					mstate = STATE_CODE_FWD;
				end else begin
					cmd_speed = -speed_full;
					mstate = STATE_CODE_REV;
				end
			end
			FUNC_START_FWD: begin
				cmd_speed = speed_full;
				tgt_pos = lim_max[POS_BITS-1:0];
				mstate = STATE_CODE_FWD;
				sens_on = 1'b1;
			end
			FUNC_START_REV: begin
				cmd_speed = -speed_full;
				tgt_pos = lim_min[POS_BITS-1:0];
				mstate = STATE_CODE_REV;
				sens_on = 1'b1;
			end
			FUNC_STOP: begin
				tgt_pos = '0;
				mstate = STATE_CODE_IDLE;
			end
			default: ;
		endcase
		o = '0;
		if (ramp_speed >= 0) begin
			o.fwd = ramp_speed[PWM_BITS-1:0];
		end else begin
			neg = -ramp_speed;
			o.rev = neg[PWM_BITS-1:0];
		end
		o.pwr = sens_on;
		o.st = mstate;
		o.chg = (mstate != prior);
		return o;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		r = $urandom_range(99);
		if (steady || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Called at a falling edge; returns at a falling edge with valid possibly still high.
	task automatic send_cmd(logic [FUNC_BITS-1:0] f, logic [POS_BITS-1:0] req,
			logic [POS_BITS-1:0] smp, logic use_typed, drive_out_t typed_res);
		drive_out_t want;
		int gap;
		cmd_if.func <= f;
		cmd_if.requested_position <= req;
		cmd_if.sensor_sample <= smp;
		cmd_if.valid <= 1'b1;
		@(posedge clk);
		while (!cmd_if.ready)
			@(posedge clk);
		want = controller_step(f, req, smp);
		if (use_typed)
			want = typed_res;
		duty_expected_q.push_back(want);
		@(negedge clk);
		gap = pick_gap(src_steady);
		if (gap > 0) begin
			cmd_if.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic set_reg(cfg_reg_t idx, int unsigned v);
		logic [CFG_DATA_BITS-1:0] d;
		// junk above the register width half the time
		d = $urandom_range(1) ? 16'($urandom) : '0;
		if (idx == REG_RAMP_STEP || idx == REG_FULL_SPEED)
			d[PWM_BITS-1:0] = v[PWM_BITS-1:0];
		else
			d[POS_BITS-1:0] = v[POS_BITS-1:0];
		cfg_if.index <= idx;
		cfg_if.data <= d;
		cfg_if.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		case (idx)
			REG_MAX_POSITION:     lim_max = int'(d[POS_BITS-1:0]);
			REG_MIN_POSITION:     lim_min = int'(d[POS_BITS-1:0]);
			REG_ARRIVE_THRESHOLD: arrive_thr = int'(d[POS_BITS-1:0]);
			REG_SLOW_ZONE:        slow_thr = int'(d[POS_BITS-1:0]);
			REG_RAMP_STEP:        step_max = int'(d[PWM_BITS-1:0]);
			REG_FULL_SPEED:       speed_full = int'(d[PWM_BITS-1:0]);
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic write_settings(int unsigned mx, int unsigned mn, int unsigned thr,
			int unsigned slow, int unsigned step, int unsigned full);
		set_reg(REG_MAX_POSITION, mx);
		set_reg(REG_MIN_POSITION, mn);
		set_reg(REG_ARRIVE_THRESHOLD, thr);
		set_reg(REG_SLOW_ZONE, slow);
		set_reg(REG_RAMP_STEP, step);
		set_reg(REG_FULL_SPEED, full);
		cfg_if.valid <= 1'b0;
		@(negedge clk);
	endtask

	// drop valid, then wait until every expected result has been taken
	task automatic drain;
		cmd_if.valid <= 1'b0;
		while (duty_expected_q.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	// Commands followed mostly by ticks whose samples walk toward the aim; some noise.
	task automatic run_motion(int n);
		int aim;
		int pos;
		int r;
		int stp;
		int jit;
		logic [FUNC_BITS-1:0] f;
		logic [POS_BITS-1:0] req;
		logic [POS_BITS-1:0] smp;
		aim = $urandom_range(4095);
		pos = $urandom_range(4095);
		repeat (n) begin
			r = $urandom_range(99);
			req = POS_BITS'($urandom_range(4095));
			smp = pos[POS_BITS-1:0];
			if (r < 8) begin
				f = FUNC_BITS'($urandom_range(7));
				smp = POS_BITS'($urandom_range(4095));
			end else if (r < 22) begin
				case ($urandom_range(5))
					0, 1, 2: begin
						f = FUNC_MOVE;
						if ($urandom_range(7) == 0)
							req = $urandom_range(1) ? '1 : '0;
						aim = int'(req);
					end
					3: begin
						f = FUNC_START_FWD;
						aim = lim_max;
					end
					4: begin
						f = FUNC_START_REV;
						aim = lim_min;
					end
					default: f = FUNC_STOP;
				endcase
			end else begin
				f = FUNC_TICK;
				stp = $urandom_range(250);
				if ($urandom_range(19) == 0)
					pos = $urandom_range(4095);
				else if (pos < aim)
					pos = (aim - pos > stp) ? pos + stp : aim;
				else
					pos = (pos - aim > stp) ? pos - stp : aim;
				jit = pos + $urandom_range(40) - 20;
				if (jit < 0)
					jit = 0;
				if (jit > 4095)
					jit = 4095;
				smp = jit[POS_BITS-1:0];
			end
			send_cmd(f, req, smp, 1'b0, '0);
		end
	endtask

	task automatic check_field(string fname, logic [15:0] want_v, logic [15:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s expected %0d, got %0d", $time, fname, want_v, got_v);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		drive_out_t want;
		if (arst_n && res_if.valid && res_if.ready) begin
			if (duty_expected_q.size() == 0) begin
				$display("%0t: result with nothing expected: fwd %0d rev %0d pwr %0d st %0d chg %0d",
					$time, res_if.forward_duty, res_if.reverse_duty, res_if.sensor_power,
					res_if.motor_state, res_if.state_changed);
				fail_count++;
			end else begin
				want = duty_expected_q.pop_front();
				check_field("forward_duty", 16'(want.fwd), 16'(res_if.forward_duty));
				check_field("reverse_duty", 16'(want.rev), 16'(res_if.reverse_duty));
				check_field("sensor_power", 16'(want.pwr), 16'(res_if.sensor_power));
				check_field("motor_state", 16'(want.st), 16'(res_if.motor_state));
				check_field("state_changed", 16'(want.chg), 16'(res_if.state_changed));
			end
		end
	end

	// result side: random stalls, plus one long hold while the source keeps offering
	initial begin
		int hold;
		res_if.ready = 1'b0;
		hold = 0;
		forever begin
			@(negedge clk);
			if (squeeze_req) begin
				squeeze_req = 1'b0;
				res_if.ready <= 1'b0;
				hold = SQUEEZE_CYCLES;
			end else if (hold > 0) begin
				hold--;
			end else if (!sink_steady && $urandom_range(99) < 25) begin
				res_if.ready <= 1'b0;
				hold = ($urandom_range(9) == 0) ? $urandom_range(10, 30) : $urandom_range(3);
			end else begin
				res_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("ramped_position_motor_controller_top: mismatch");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cmd_if.valid = 1'b0;
		cmd_if.func = FUNC_TICK;
		cmd_if.requested_position = '0;
		cmd_if.sensor_sample = '0;
		cfg_if.valid = 1'b0;
		cfg_if.index = REG_MAX_POSITION;
		cfg_if.data = '0;
		lim_max = 4095;
		lim_min = 0;
		arrive_thr = RESET_ARRIVE_THRESHOLD;
		slow_thr = RESET_SLOW_ZONE;
		step_max = RESET_RAMP_STEP;
		speed_full = 8191;
		tgt_pos = '0;
		cmd_speed = 0;
		ramp_speed = 0;
		mstate = STATE_CODE_IDLE;
		sens_on = 1'b0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].f, dir_rows[i].req, dir_rows[i].smp, dir_rows[i].typed,
				dir_rows[i].res);
		drain();

		for (int p = 0; p < PHASES; p++) begin
			if (p == 0)
				write_settings(4095, 0, 0, 4095, 8191, 8191);
			else if (p == 1)
				write_settings(0, 4095, 4095, 0, 1, 0);
			else
				write_settings($urandom_range(4095),
					$urandom_range(3) == 0 ? $urandom_range(4095) : $urandom_range(1500),
					$urandom_range(120), $urandom_range(1500),
					$urandom_range(19) == 0 ? 0 : $urandom_range(1, 1500),
					$urandom_range(8191));
			src_steady = (p == 3) || ($urandom_range(3) == 0);
			sink_steady = (p != 3) && ($urandom_range(3) == 0);
			if (p == 3)
				squeeze_req = 1'b1;
			run_motion(PHASE_ITEMS);
			drain();
		end

		if (fail_count == 0)
			$display("ramped_position_motor_controller_top: match");
		else
			$display("ramped_position_motor_controller_top: mismatch");
		$finish;
	end

endmodule
`default_nettype wire
